>>> hw/rtl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types, codes and sizes for the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 32;
    localparam int HASH_W   = 32;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 8;
    localparam int OCC_W    = 9;

    // Hash reduction takes this many hash bits per cycle
    localparam int HASH_DIGIT_W = 4;

    localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 8'd192;

    localparam logic [FUNC_W-1:0] FUNC_GET = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic               used;
        logic               tomb;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_t;

endpackage

>>> hw/rtl/oaht_hash_mod.sv
// ----------------------------------------------------------------------------
// oaht_hash_mod
// Reduces a 32-bit hash modulo the table capacity: a mask for a power of
// two, otherwise a restoring remainder over HASH_DIGIT_W hash bits per cycle.
// ----------------------------------------------------------------------------
module oaht_hash_mod
    import oaht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] hash,
    output logic              done,
    output logic [AW-1:0]     index
);

    localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

    logic          done_reg;
    logic [AW-1:0] rem_reg;

    assign done  = done_reg;
    assign index = rem_reg;

    generate
        if (IS_POW2) begin : g_mask
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= hash[AW-1:0];
                end
            end
        end
        else begin : g_div
            localparam int STEPS = HASH_W / HASH_DIGIT_W;
            localparam int CW    = $clog2(STEPS);
            localparam logic [AW:0] CAP_W = (AW + 1)'(CAPACITY);

            logic              busy_reg;
            logic [CW-1:0]     cnt_reg;
            logic [HASH_W-1:0] hash_reg;
            logic [AW-1:0]     rem_next;

            // one restoring step per hash bit, remainder stays below capacity
            always_comb
            begin
                logic [AW:0] t;
                t        = '0;
                rem_next = rem_reg;
                for (int i = 0; i < HASH_DIGIT_W; i++)
                begin
                    t = {rem_next, hash_reg[HASH_W-1-i]};
                    if (t >= CAP_W)
                    begin
                        t = t - CAP_W;
                    end
                    rem_next = t[AW-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= '0;
                    end
                    else if (busy_reg)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == CW'(STEPS - 1))
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    hash_reg <= hash;
                    rem_reg  <= '0;
                end
                else if (busy_reg)
                begin
                    hash_reg <= hash_reg << HASH_DIGIT_W;
                    rem_reg  <= rem_next;
                end
            end
        end
    endgenerate

endmodule

>>> hw/rtl/oaht_slot_mem.sv
// ----------------------------------------------------------------------------
// oaht_slot_mem
// Slot store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oaht_slot_mem
    import oaht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  slot_t         wdata,
    input  logic [AW-1:0] raddr,
    output slot_t         rdata
);

    slot_t mem_arr [CAPACITY];
    slot_t rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_arr[waddr] <= wdata;
        end
        rdata_reg <= mem_arr[raddr];
    end

endmodule

>>> hw/rtl/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Linear-probing key/value map with tombstones: get, set and delete.
// ----------------------------------------------------------------------------
// After reset the block clears its slot store, one slot after another, and
// takes no request until that pass ends. Each request then runs alone: the
// hash is reduced modulo CAPACITY (a mask for a power-of-two capacity, a
// restoring remainder otherwise), the probe walks the table through the
// single read port, reading a slot in ST_READ and judging it in ST_CHECK,
// and the result passes through ST_DONE into the output register. An unused
// operation code skips the hash and the probe and goes straight to ST_DONE.
// A waiting result holds the next request at its last step, so only one
// further request is taken while it waits.
module open_addressing_hash_table
    import oaht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // s_tdata: func[1:0], key_id[33:2], key_hash[65:34], write_value[129:66]
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [135:0]       s_tdata,
    // m_tdata: status[1:0], new_key[2], read_value[66:3]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [71:0]        m_tdata,
    input  logic               load_limit_we,
    input  logic [LIMIT_W-1:0] load_limit_wdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]          state_reg,    state_next;
    logic [AW-1:0]       idx_reg,      idx_next;
    logic [NW-1:0]       n_reg,        n_next;
    logic                tomb_reg,     tomb_next;
    logic [AW-1:0]       tomb_at_reg,  tomb_at_next;
    logic [OCC_W-1:0]    occ_reg,      occ_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [FUNC_W-1:0]   func_reg,     func_next;
    logic [KEY_W-1:0]    key_reg,      key_next;
    logic [VALUE_W-1:0]  wval_reg,     wval_next;
    logic [STATUS_W-1:0] status_reg,   status_next;
    logic                new_reg,      new_next;
    logic [VALUE_W-1:0]  rval_reg,     rval_next;
    logic                out_vld_reg,  out_vld_next;
    logic [71:0]         out_data_reg, out_data_next;

    logic          mod_start;
    logic          mod_done;
    logic [AW-1:0] mod_index;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    slot_t         mem_wdata;
    slot_t         rd;

    logic          in_fire;
    logic          hit;
    logic          empty;
    logic          last;
    logic          tomb_eff;
    logic [AW-1:0] tomb_at_eff;
    logic          fresh;
    logic          has_slot;
    logic [AW-1:0] slot_at;
    logic          over_limit;

    oaht_hash_mod #(
        .CAPACITY (CAPACITY)
    ) u_hash_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .hash  (s_tdata[65:34]),
        .done  (mod_done),
        .index (mod_index)
    );

    oaht_slot_mem #(
        .CAPACITY (CAPACITY)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx_reg),
        .rdata (rd)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // probe decisions on the slot just read
    assign hit         = rd.used && (rd.key == key_reg);
    assign empty       = !rd.used && !rd.tomb;
    assign last        = (n_reg == NW'(CAPACITY - 1));
    assign tomb_eff    = tomb_reg || (!rd.used && rd.tomb);
    assign tomb_at_eff = tomb_reg ? tomb_at_reg : idx_reg;
    assign has_slot    = empty || tomb_eff;
    assign fresh       = empty && !tomb_eff;
    assign slot_at     = tomb_eff ? tomb_at_eff : idx_reg;
    assign over_limit  = ({1'b0, occ_reg} + (OCC_W + 1)'(1)) >
                         (OCC_W + 1)'(limit_reg);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        tomb_next     = tomb_reg;
        tomb_at_next  = tomb_at_reg;
        occ_next      = occ_reg;
        func_next     = func_reg;
        key_next      = key_reg;
        wval_next     = wval_reg;
        status_next   = status_reg;
        new_next      = new_reg;
        rval_next     = rval_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_data_next = out_data_reg;
        mod_start     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == AW'(CAPACITY - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    func_next   = s_tdata[1:0];
                    key_next    = s_tdata[33:2];
                    wval_next   = s_tdata[129:66];
                    status_next = STATUS_NOT_FOUND;
                    new_next    = 1'b0;
                    rval_next   = '0;
                    if (s_tdata[1:0] == FUNC_GET || s_tdata[1:0] == FUNC_SET ||
                        s_tdata[1:0] == FUNC_DEL)
                    begin
                        mod_start  = 1'b1;
                        state_next = ST_HASH;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_HASH:
            begin
                if (mod_done)
                begin
                    idx_next   = mod_index;
                    n_next     = '0;
                    tomb_next  = 1'b0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (hit)
                begin
                    status_next = STATUS_DONE;
                    state_next  = ST_DONE;
                    if (func_reg == FUNC_GET)
                    begin
                        rval_next = rd.value;
                    end
                    else if (func_reg == FUNC_SET)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = '{used: 1'b1, tomb: 1'b0, key: key_reg,
                                      value: wval_reg};
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = '{used: 1'b0, tomb: 1'b1, key: rd.key,
                                      value: rd.value};
                    end
                end
                else if (empty || last)
                begin
                    state_next = ST_DONE;
                    if (func_reg == FUNC_SET)
                    begin
                        if (!has_slot || (fresh && over_limit))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = slot_at;
                            mem_wdata   = '{used: 1'b1, tomb: 1'b0, key: key_reg,
                                            value: wval_reg};
                            status_next = STATUS_DONE;
                            new_next    = 1'b1;
                            if (fresh)
                            begin
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                    end
                end
                else
                begin
                    // advance, remembering the first tombstone passed
                    tomb_next    = tomb_eff;
                    tomb_at_next = tomb_at_eff;
                    n_next       = n_reg + 1'b1;
                    idx_next     = (idx_reg == AW'(CAPACITY - 1)) ? '0 : idx_reg + 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = {5'b0, rval_reg, new_reg, status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            n_reg       <= '0;
            tomb_reg    <= 1'b0;
            occ_reg     <= '0;
            limit_reg   <= LOAD_LIMIT_RST;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            n_reg       <= n_next;
            tomb_reg    <= tomb_next;
            occ_reg     <= occ_next;
            out_vld_reg <= out_vld_next;
            if (load_limit_we)
            begin
                limit_reg <= load_limit_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tomb_at_reg  <= tomb_at_next;
        func_reg     <= func_next;
        key_reg      <= key_next;
        wval_reg     <= wval_next;
        status_reg   <= status_next;
        new_reg      <= new_next;
        rval_reg     <= rval_next;
        out_data_reg <= out_data_next;
    end

    a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg <= OCC_W'(CAPACITY)) || (occ_reg <= OCC_W'(255)))
        else $error("occupancy count beyond table size");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_CHECK))
        else $error("slot write outside clear pass or probe check");

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_HASH || state_reg == ST_DONE))
        else $error("accepted transaction did not start work");

    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_vld_reg || m_tready)) |=> m_tvalid)
        else $error("finished request produced no result");

endmodule
